@@ rtl/core/epf_pkg.sv @@
// ----------------------------------------------------------------------------
// epf_pkg
// shared types and constants of the binned echo peak finder
// ----------------------------------------------------------------------------
package epf_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int POS_W       = 10;
	localparam int BIN_W       = 10;
	localparam int DIST_W      = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - POS_W - SAMPLE_W - BIN_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMP_MIN      = 2'd0,
		REG_AMP_MAX      = 2'd1,
		REG_MIN_DISTANCE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                last;
		logic [BIN_W-1:0]    bin;
		logic [SAMPLE_W-1:0] amplitude;
		logic [POS_W-1:0]    position;
	} result_t;

	// up to two results per accepted sample, oldest in item0
	typedef struct packed {
		logic [1:0] count;
		result_t    item0;
		result_t    item1;
	} push_t;

	typedef struct packed {
		logic              valid;
		logic [QLVL_W-1:0] level;
	} queue_status_t;

endpackage

@@ rtl/core/epf_front.sv @@
// ----------------------------------------------------------------------------
// epf_front
// peak classification, bin tracking and configuration registers
// ----------------------------------------------------------------------------
module epf_front #(
	parameter int MAX_FRAME_LEN = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [epf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [epf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_beat,
	input  logic [epf_pkg::SAMPLE_W-1:0]        sample,
	input  logic                                frame_end,
	output epf_pkg::push_t                      push
);
	import epf_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);

	logic [SAMPLE_W-1:0] amp_min_q, amp_max_q;
	logic [DIST_W-1:0]   min_distance_q;

	logic [SAMPLE_W-1:0] cand_q, left_q, best_amp_q;
	logic                left_valid_q, best_valid_q;
	logic [CNT_W-1:0]    count_q;
	logic [POS_W-1:0]    offset_q, best_pos_q;
	logic [BIN_W-1:0]    bin_q, best_bin_q;

	logic [SAMPLE_W-1:0] cand_d, left_d, best_amp_d;
	logic                left_valid_d, best_valid_d;
	logic [CNT_W-1:0]    count_d, count_m1;
	logic [POS_W-1:0]    offset_d, best_pos_d;
	logic [BIN_W-1:0]    bin_d, best_bin_d;
	logic [DIST_W-1:0]   width, offset_inc;
	logic                is_peak, split;
	result_t             old_best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_min_q      <= SAMPLE_W'(1);
			amp_max_q      <= '1;
			min_distance_q <= DIST_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AMP_MIN:      amp_min_q      <= cfg_data;
				REG_AMP_MAX:      amp_max_q      <= cfg_data;
				REG_MIN_DISTANCE: min_distance_q <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	assign width      = (min_distance_q == '0) ? DIST_W'(1) : min_distance_q;
	assign offset_inc = {1'b0, offset_q} + DIST_W'(1);
	assign count_m1   = count_q - CNT_W'(1);
	assign is_peak    = left_valid_q && (left_q < cand_q) && (sample < cand_q)
		&& (cand_q >= amp_min_q) && (cand_q <= amp_max_q);

	always_comb begin
		cand_d       = cand_q;
		left_d       = left_q;
		left_valid_d = left_valid_q;
		count_d      = count_q;
		offset_d     = offset_q;
		bin_d        = bin_q;
		best_valid_d = best_valid_q;
		best_pos_d   = best_pos_q;
		best_amp_d   = best_amp_q;
		best_bin_d   = best_bin_q;
		split        = 1'b0;
		old_best     = '{last: 1'b0, bin: best_bin_q, amplitude: best_amp_q,
			position: best_pos_q};
		push         = '0;

		if (in_beat) begin
			if (count_q < CNT_W'(MAX_FRAME_LEN)) begin
				if (count_q != '0) begin
					if (is_peak) begin
						// a peak in a newer bin closes the open one
						split = best_valid_q && (best_bin_q != bin_q);
						if (split) best_valid_d = 1'b0;
						if (!best_valid_d || (cand_q > best_amp_q)) begin
							best_valid_d = 1'b1;
							best_pos_d   = POS_W'(count_m1);
							best_amp_d   = cand_q;
							best_bin_d   = bin_q;
						end
					end
					if (sample != cand_q) begin
						left_d       = cand_q;
						left_valid_d = 1'b1;
					end
					if (offset_inc >= width) begin
						offset_d = '0;
						bin_d    = bin_q + BIN_W'(1);
					end else begin
						offset_d = offset_inc[POS_W-1:0];
					end
				end else begin
					offset_d     = '0;
					bin_d        = '0;
					left_valid_d = 1'b0;
					left_d       = '0;
				end
				cand_d  = sample;
				count_d = count_q + CNT_W'(1);
			end

			if (split) begin
				push.count = 2'd1;
				push.item0 = old_best;
			end

			if (frame_end) begin
				if (best_valid_d) begin
					if (split) begin
						push.count = 2'd2;
						push.item1 = '{last: 1'b1, bin: best_bin_d,
							amplitude: best_amp_d, position: best_pos_d};
					end else begin
						push.count = 2'd1;
						push.item0 = '{last: 1'b1, bin: best_bin_d,
							amplitude: best_amp_d, position: best_pos_d};
					end
				end
				cand_d       = '0;
				left_d       = '0;
				left_valid_d = 1'b0;
				count_d      = '0;
				offset_d     = '0;
				bin_d        = '0;
				best_valid_d = 1'b0;
				best_pos_d   = '0;
				best_amp_d   = '0;
				best_bin_d   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q       <= '0;
			left_q       <= '0;
			left_valid_q <= 1'b0;
			count_q      <= '0;
			offset_q     <= '0;
			bin_q        <= '0;
			best_valid_q <= 1'b0;
			best_pos_q   <= '0;
			best_amp_q   <= '0;
			best_bin_q   <= '0;
		end else begin
			cand_q       <= cand_d;
			left_q       <= left_d;
			left_valid_q <= left_valid_d;
			count_q      <= count_d;
			offset_q     <= offset_d;
			bin_q        <= bin_d;
			best_valid_q <= best_valid_d;
			best_pos_q   <= best_pos_d;
			best_amp_q   <= best_amp_d;
			best_bin_q   <= best_bin_d;
		end
	end

endmodule

@@ rtl/core/epf_queue.sv @@
// ----------------------------------------------------------------------------
// epf_queue
// small result queue, takes up to two entries a cycle and gives one
// ----------------------------------------------------------------------------
module epf_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  epf_pkg::push_t        push,
	input  logic                  pop,
	output epf_pkg::result_t      head,
	output epf_pkg::queue_status_t status
);
	import epf_pkg::*;

	result_t           entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              do_pop;

	assign do_pop = pop && (level_q != '0);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) entries_q[wr_ptr_q] <= push.item0;
		if (push.count == 2'd2) entries_q[wr_ptr_q + QPTR_W'(1)] <= push.item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			level_q  <= level_q + QLVL_W'(push.count) - QLVL_W'(do_pop);
		end
	end

	assign head         = entries_q[rd_ptr_q];
	assign status.valid = (level_q != '0);
	assign status.level = level_q;

endmodule

@@ rtl/core/epf_back.sv @@
// ----------------------------------------------------------------------------
// epf_back
// output register that drains the result queue one beat at a time
// ----------------------------------------------------------------------------
module epf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  epf_pkg::result_t q_head,
	output logic             q_pop,
	output logic             out_valid,
	output epf_pkg::result_t out_item,
	input  logic             out_ready
);
	import epf_pkg::*;

	logic    valid_q;
	result_t item_q;

	assign q_pop = q_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) item_q <= q_head;
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

@@ rtl/core/echo_peak_finder_binned.sv @@
// ----------------------------------------------------------------------------
// echo_peak_finder_binned
// streaming echo peak finder that reports the highest peak of each distance bin
// ----------------------------------------------------------------------------
// one sample beat is taken every cycle while s_tready is high. the front stage
// judges the previous sample against its neighbors and the limits in the cycle
// the beat arrives and keeps the best peak of the open bin; a sample can close
// at most two bins (a peak in a newer bin plus frame end), so each beat pushes
// zero to two results into a four-entry queue. an output register drains the
// queue at one result per cycle while m_tready is high; s_tready drops only
// while the queue has fewer than two free entries. a released result goes to
// the queue, then the output register. there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module echo_peak_finder_binned #(
	parameter int MAX_FRAME_LEN = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [epf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [epf_pkg::CFG_DATA_W-1:0]     cfg_data,
	// sample stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [epf_pkg::IN_TDATA_W-1:0]     s_tdata,   // sample[15:0]
	input  logic                               s_tlast,   // frame_end
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// peak_position[9:0], peak_amplitude[25:10], bin_index[35:26], zero pad
	output logic [epf_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                               m_tlast    // last_of_frame
);
	import epf_pkg::*;

	logic          in_beat;
	push_t         push;
	result_t       q_head, out_item;
	queue_status_t q_status;
	logic          q_pop;

	// room for the worst case of two results from the next beat
	assign s_tready = (q_status.level <= QLVL_W'(QUEUE_DEPTH - 2));
	assign in_beat  = s_tvalid && s_tready;

	epf_front #(
		.MAX_FRAME_LEN(MAX_FRAME_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_beat   (in_beat),
		.sample    (s_tdata[SAMPLE_W-1:0]),
		.frame_end (s_tlast),
		.push      (push)
	);

	epf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (q_pop),
		.head   (q_head),
		.status (q_status)
	);

	epf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_status.valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_item  (out_item),
		.out_ready (m_tready)
	);

	// pack result fields, position in the low bits
	assign m_tdata = {{OUT_PAD_W{1'b0}}, out_item.bin, out_item.amplitude,
		out_item.position};
	assign m_tlast = out_item.last;

	// queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.level <= QLVL_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// a double push only lands when two entries were free
	a_double_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (q_status.level <= QLVL_W'(QUEUE_DEPTH - 2)))
		else $error("double push without room");

	// an idle output register picks up a waiting result in the next cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && q_status.valid) |=> m_tvalid)
		else $error("queued result not moved to output");

endmodule
